// ===== rtl/core/u8san_pkg.sv =====
// Shared types, constants and classification functions for the UTF-8 stream sanitizer.
package u8san_pkg;

  localparam int unsigned RunMax    = 4;
  localparam int unsigned RunIdxW   = $clog2(RunMax);
  localparam int unsigned HeldDepth = 3;
  localparam int unsigned HeldIdxW  = $clog2(HeldDepth);
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QAddrW    = $clog2(QDepth);

  localparam logic [7:0] AsciiMax   = 8'h7F;
  localparam logic [7:0] Lead2Min   = 8'hC2;
  localparam logic [7:0] Lead2Max   = 8'hDF;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead3Max   = 8'hEF;
  localparam logic [7:0] Lead4Min   = 8'hF0;
  localparam logic [7:0] Lead4Max   = 8'hF4;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContTag    = 8'h80;
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadED     = 8'hED;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] LeadF4     = 8'hF4;
  localparam logic [7:0] MinAfterE0 = 8'hA0;
  localparam logic [7:0] MaxAfterED = 8'h9F;
  localparam logic [7:0] MinAfterF0 = 8'h90;
  localparam logic [7:0] MaxAfterF4 = 8'h8F;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
  } out_beat_t;

  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [RunIdxW-1:0]     len_m1;
    logic                   has_data;
    logic                   last;
  } run_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = LenNone;
    if (b >= Lead2Min && b <= Lead2Max) len = LenTwo;
    else if (b >= Lead3Min && b <= Lead3Max) len = LenThree;
    else if (b >= Lead4Min && b <= Lead4Max) len = LenFour;
    return len;
  endfunction

  function automatic logic second_byte_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    if (lead == LeadE0 && b < MinAfterE0) ok = 1'b0;
    if (lead == LeadED && b > MaxAfterED) ok = 1'b0;
    if (lead == LeadF0 && b < MinAfterF0) ok = 1'b0;
    if (lead == LeadF4 && b > MaxAfterF4) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ===== rtl/core/u8san_front.sv =====
// Front end: accepts input beats, tracks the open sequence and forms complete runs.
module u8san_front import u8san_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  input  logic     q_full,
  output logic     push,
  output run_t     push_run
);

  logic [7:0]          held [HeldDepth];
  logic [2:0]          exp_len;
  logic [2:0]          exp_len_next;
  logic [HeldIdxW-1:0] held_count;
  logic [HeldIdxW-1:0] held_count_next;
  logic                hold_wr;
  logic [HeldIdxW-1:0] hold_idx;
  logic [7:0]          b;
  logic                ok;
  logic                handled;
  logic                emit;
  logic [2:0]          len;
  run_t                run;

  assign in_ready = !q_full;
  assign b        = in_beat.in_byte;

  always_comb begin
    exp_len_next    = exp_len;
    held_count_next = held_count;
    hold_wr         = 1'b0;
    hold_idx        = held_count;
    handled         = 1'b0;
    emit            = 1'b0;
    len             = lead_len(b);
    run             = '0;
    ok = ((b & ContMask) == ContTag) &&
         ((held_count != HeldIdxW'(1)) || second_byte_ok(held[0], b));

    if (exp_len != LenNone) begin
      if (ok) begin
        handled = 1'b1;
        if (({1'b0, held_count} + 3'd1) >= exp_len) begin
          emit = 1'b1;
          for (int k = 0; k < RunMax - 1; k++) begin
            run.bytes[k] = (RunIdxW'(k) < RunIdxW'(held_count)) ? held[k] : b;
          end
          run.bytes[RunMax-1] = b;
          run.len_m1          = RunIdxW'(held_count);
          exp_len_next        = LenNone;
          held_count_next     = '0;
        end else begin
          hold_wr         = 1'b1;
          hold_idx        = held_count;
          held_count_next = held_count + HeldIdxW'(1);
        end
      end else begin
        exp_len_next    = LenNone;
        held_count_next = '0;
      end
    end

    if (!handled) begin
      if (b <= AsciiMax) begin
        emit   = 1'b1;
        run.bytes = {RunMax{b}};
        run.len_m1 = '0;
      end else if (len != LenNone) begin
        hold_wr         = 1'b1;
        hold_idx        = '0;
        held_count_next = HeldIdxW'(1);
        exp_len_next    = len;
      end
    end

    if (in_beat.string_last) begin
      exp_len_next    = LenNone;
      held_count_next = '0;
    end

    run.has_data = emit;
    run.last     = in_beat.string_last;
  end

  assign push     = in_valid && in_ready && (emit || in_beat.string_last);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len    <= LenNone;
      held_count <= '0;
    end else if (in_valid && in_ready) begin
      exp_len    <= exp_len_next;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && hold_wr) begin
      held[hold_idx] <= b;
    end
  end

endmodule

// ===== rtl/core/u8san_queue.sv =====
// Short run queue between the front end and the back end.
module u8san_queue import u8san_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  run_t push_run,
  output logic full,
  input  logic pop,
  output logic empty,
  output run_t head
);

  run_t              slots [QDepth];
  logic [QAddrW-1:0] wr_ptr;
  logic [QAddrW-1:0] rd_ptr;
  logic [QAddrW:0]   count;

  assign full  = (count == (QAddrW+1)'(QDepth));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAddrW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAddrW'(1);
      if (push && !pop) count <= count + (QAddrW+1)'(1);
      else if (pop && !push) count <= count - (QAddrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_run;
  end

endmodule

// ===== rtl/core/u8san_back.sv =====
// Back end: unrolls queued runs into output beats through an output register.
module u8san_back import u8san_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      empty,
  input  run_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic [RunIdxW-1:0] idx;
  logic               load;
  logic               at_end;

  assign load   = !empty && (!out_valid || out_ready);
  assign at_end = (idx == head.len_m1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= at_end ? '0 : idx + RunIdxW'(1);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_beat.out_byte   <= head.bytes[idx];
      out_beat.byte_valid <= head.has_data;
      out_beat.run_last   <= at_end;
      out_beat.string_end <= at_end && head.last;
    end
  end

endmodule

// ===== rtl/core/utf8_stream_sanitizer_unit.sv =====
// Top level of the UTF-8 stream sanitizer: front end, run queue and back end.
//
//   channel | direction | payload    | handshake
//   input   | in        | in_beat_t  | in_valid / in_ready
//   output  | out       | out_beat_t | out_valid / out_ready
//
// One input beat per cycle; in_ready drops only while the four-entry run queue is full.
// Each run leaves as one output beat per cycle while out_ready is high.
// The first output beat of a run passes through the run queue and then the output register.
// rst (synchronous) empties the queue, the output register and any open sequence.
module utf8_stream_sanitizer_unit import u8san_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic push;
  run_t push_run;
  logic q_full;
  logic q_empty;
  logic pop;
  run_t head;

  u8san_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .q_full   (q_full),
    .push     (push),
    .push_run (push_run)
  );

  u8san_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  u8san_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

// ===== rtl/core/u8san_checker.sv =====
// Port-level checks for the UTF-8 stream sanitizer, bound to the top level.
module u8san_checker import u8san_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_beat,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_beat
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("output beat changed while stalled");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.string_end |-> out_beat.run_last)
    else $error("string end without run end");

  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_beat.byte_valid |-> out_beat.run_last && out_beat.string_end)
    else $error("empty beat that is not a bare end marker");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_stream_sanitizer_unit u8san_checker u_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the UTF-8 stream sanitizer with a scoreboard class and beat drivers.
module tb;
  import u8san_pkg::*;

  class utf8_run_scoreboard;
    logic [7:0] seq_bytes [3];
    logic [2:0] seq_len;
    logic [1:0] seq_count;
    out_beat_t  expected_beats [$];
    int         errors;

    function new();
      foreach (seq_bytes[k]) seq_bytes[k] = '0;
      seq_len   = LenNone;
      seq_count = '0;
      errors    = 0;
    endfunction

    function bit second_in_range(logic [7:0] lead, logic [7:0] b);
      if (lead == LeadE0 && b < MinAfterE0) return 1'b0;
      if (lead == LeadED && b > MaxAfterED) return 1'b0;
      if (lead == LeadF0 && b < MinAfterF0) return 1'b0;
      if (lead == LeadF4 && b > MaxAfterF4) return 1'b0;
      return 1'b1;
    endfunction

    function void accept_byte(in_beat_t beat);
      logic [7:0] run [4];
      logic [7:0] b;
      logic [2:0] lead_len;
      out_beat_t  res;
      int         n;
      bit         taken;
      bit         ok;
      b     = beat.in_byte;
      n     = 0;
      taken = 1'b0;
      if (seq_len != LenNone) begin
        ok = (b & ContMask) == ContTag;
        if (ok && seq_count == 2'd1) ok = second_in_range(seq_bytes[0], b);
        if (ok) begin
          taken = 1'b1;
          if (int'(seq_count) + 1 >= int'(seq_len)) begin
            for (int k = 0; k < int'(seq_count); k++) begin
              run[n] = seq_bytes[k];
              n++;
            end
            run[n]    = b;
            n++;
            seq_len   = LenNone;
            seq_count = '0;
          end else begin
            seq_bytes[seq_count] = b;
            seq_count = seq_count + 2'd1;
          end
        end else begin
          seq_len   = LenNone;
          seq_count = '0;
        end
      end
      if (!taken) begin
        lead_len = LenNone;
        if (b <= AsciiMax) begin
          run[n] = b;
          n++;
        end
        else if (b >= Lead2Min && b <= Lead2Max) lead_len = LenTwo;
        else if (b >= Lead3Min && b <= Lead3Max) lead_len = LenThree;
        else if (b >= Lead4Min && b <= Lead4Max) lead_len = LenFour;
        if (lead_len != LenNone) begin
          seq_bytes[0] = b;
          seq_count    = 2'd1;
          seq_len      = lead_len;
        end
      end
      if (beat.string_last) begin
        seq_len   = LenNone;
        seq_count = '0;
      end
      if (n == 0) begin
        if (beat.string_last) begin
          res = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1, string_end: 1'b1};
          expected_beats.insert(expected_beats.size(), res);
        end
      end else begin
        for (int k = 0; k < n; k++) begin
          res.out_byte   = run[k];
          res.byte_valid = 1'b1;
          res.run_last   = (k == n - 1);
          res.string_end = (k == n - 1) && beat.string_last;
          expected_beats.insert(expected_beats.size(), res);
        end
      end
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("output beat %h arrived with nothing expected", got);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %b, actual %b", want.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
        errors++;
      end
      if (got.string_end !== want.string_end) begin
        $error("string_end: expected %b, actual %b", want.string_end, got.string_end);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_beat;

  utf8_run_scoreboard sb;
  in_beat_t           stim [$];
  logic [8:0]         directed [$];
  int                 sent;
  bit                 quiet;

  utf8_stream_sanitizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.accept_byte(in_beat);
      if (out_valid && out_ready) sb.check_beat(out_beat);
    end
  end

  initial begin
    int hold_left;
    bit long_done;
    hold_left = 0;
    long_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!long_done && sent >= 150) begin
        long_done = 1'b1;
        out_ready <= 1'b0;
        hold_left = 79;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        hold_left = $urandom_range(0, 9);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] any_cont();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  function automatic logic [7:0] pick_lead(int len);
    case (len)
      2:       return 8'($urandom_range(Lead2Min, Lead2Max));
      3:       return 8'($urandom_range(Lead3Min, Lead3Max));
      default: return 8'($urandom_range(Lead4Min, Lead4Max));
    endcase
  endfunction

  function automatic logic [7:0] legal_second(logic [7:0] lead);
    case (lead)
      LeadE0:  return 8'($urandom_range(MinAfterE0, 8'hBF));
      LeadED:  return 8'($urandom_range(8'h80, MaxAfterED));
      LeadF0:  return 8'($urandom_range(MinAfterF0, 8'hBF));
      LeadF4:  return 8'($urandom_range(8'h80, MaxAfterF4));
      default: return any_cont();
    endcase
  endfunction

  task automatic push_byte(logic [7:0] b, bit seq_end);
    in_beat_t beat;
    beat.in_byte     = b;
    beat.string_last = ($urandom_range(0, 29) == 0) || (seq_end && $urandom_range(0, 5) == 0);
    stim.insert(stim.size(), beat);
  endtask

  task automatic build_random(int count);
    int         kind;
    int         len;
    int         cnt;
    logic [7:0] lead;
    logic [7:0] bad;
    while (stim.size() < count) begin
      kind = $urandom_range(0, 9);
      case (kind)
        3, 4, 5: begin
          len  = kind - 1;
          lead = pick_lead(len);
          push_byte(lead, 1'b0);
          push_byte(legal_second(lead), len == 2);
          for (int k = 2; k < len; k++) push_byte(any_cont(), k == len - 1);
        end
        6: push_byte(8'($urandom_range(0, 255)), 1'b1);
        7: begin
          if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 3))
              0: begin lead = LeadE0; bad = 8'($urandom_range(8'h80, 8'h9F)); end
              1: begin lead = LeadED; bad = 8'($urandom_range(8'hA0, 8'hBF)); end
              2: begin lead = LeadF0; bad = 8'($urandom_range(8'h80, 8'h8F)); end
              default: begin lead = LeadF4; bad = 8'($urandom_range(8'h90, 8'hBF)); end
            endcase
            push_byte(lead, 1'b0);
            push_byte(bad, 1'b1);
          end else begin
            len  = $urandom_range(2, 4);
            lead = pick_lead(len);
            cnt  = $urandom_range(0, len - 2);
            push_byte(lead, 1'b0);
            for (int k = 0; k < cnt; k++) begin
              push_byte((k == 0) ? legal_second(lead) : any_cont(), 1'b0);
            end
            if ($urandom_range(0, 1) == 1) push_byte(8'($urandom_range(8'h00, 8'h7F)), 1'b1);
            else push_byte(8'($urandom_range(8'hC0, 8'hFF)), 1'b1);
          end
        end
        8: begin
          case ($urandom_range(0, 3))
            0:       push_byte(8'hC0, 1'b1);
            1:       push_byte(8'hC1, 1'b1);
            2:       push_byte(8'($urandom_range(8'hF5, 8'hFF)), 1'b1);
            default: push_byte(any_cont(), 1'b1);
          endcase
        end
        default: push_byte(8'($urandom_range(8'h00, AsciiMax)), 1'b1);
      endcase
    end
  endtask

  task automatic drive_byte(in_beat_t beat);
    in_beat  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int quiet_from;
    sb        = new();
    sent      = 0;
    quiet     = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_beat   <= '0;
    directed = '{9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0E0, 9'h09F, 9'h0ED, 9'h0A0, 9'h0F0,
                 9'h090, 9'h080, 9'h080, 9'h0F4, 9'h090, 9'h0C0, 9'h0C1, 9'h0F5, 9'h0FF,
                 9'h0E1, 9'h080, 9'h041, 9'h1C3, 9'h1BF, 9'h0F4, 9'h08F, 9'h0BF, 9'h1BF};
    foreach (directed[k]) begin
      stim.insert(stim.size(),
                  in_beat_t'{in_byte: directed[k][7:0], string_last: directed[k][8]});
    end
    build_random(stim.size() + 373);
    quiet_from = stim.size() - 60;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (stim[k]) begin
      quiet = (k >= quiet_from);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      drive_byte(stim[k]);
      sent++;
    end
    in_valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
